// File: rtl/htbd_pkg.sv
// Shared constants, codes and types for the Huffman tree loader and bit decoder.
`default_nettype none

package htbd_pkg;

    // Table sizes.
    localparam int NODE_SLOTS  = 512;
    localparam int STACK_SLOTS = 256;

    // Derived widths: node index, node count, stack index and stack level.
    localparam int NODE_AW  = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;
    localparam int NODE_CW  = $clog2(NODE_SLOTS + 1);
    localparam int STACK_AW = (STACK_SLOTS > 1) ? $clog2(STACK_SLOTS) : 1;
    localparam int LEVEL_W  = $clog2(STACK_SLOTS + 1);

    // Operation codes.
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_DECODE = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // Result kinds.
    localparam logic [1:0] KIND_SYMBOL   = 2'd0;
    localparam logic [1:0] KIND_COMPLETE = 2'd1;
    localparam logic [1:0] KIND_ERROR    = 2'd2;

    // One child link as kept in a parent's entry: the child's index and the
    // child's leaf symbol (zero when the child is an internal node).
    typedef struct packed {
        logic [NODE_AW-1:0] idx;
        logic [7:0]         sym;
    } t_child;

    localparam int CHILD_W = $bits(t_child);

    // One pending internal node on the load stack.
    typedef struct packed {
        logic [NODE_AW-1:0] node;
        logic               left_done;
    } t_pend;

    localparam int PEND_W = $bits(t_pend);

    // One result item.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] symbol;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/huffman_tree_bit_decoder_unit.sv
// Top level of the Huffman tree loader and bit-serial decoder.
//
// The unit takes one item per clock while the output side has room: a
// preorder tree byte, a code bit or a clear. Each item's result, if it has
// one, is registered in stage one and then loaded into the output register
// when that register is empty or being emptied; otherwise it waits in the
// skid stage. A decode bit whose walk stops on an internal node, a clear
// and a tree byte that leaves the tree unfinished give none. The tree lives
// in two child RAMs, one for left and one for right links, and each link
// also holds its child's leaf symbol, so a single registered read per bit
// tells both where the walk goes and whether it has reached a leaf. That
// read's data drives the next bit's read address directly, which sets the
// decode rate at one bit per cycle while the output side has room. Loading
// keeps the top of the pending-node stack in registers and the rest in a
// stack RAM whose next entry is fetched ahead of need, so tree bytes also
// stream at one per cycle while the output side has room. No clearing pass
// is needed after reset; tree entries are written before they can be read.
`default_nettype none

module huffman_tree_bit_decoder_unit (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [1:0] i_op,
    input  wire logic [7:0] i_tree_byte,
    input  wire logic       i_code_bit,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [1:0]      o_kind,
    output logic [7:0]      o_symbol
);

    localparam int NAW = htbd_pkg::NODE_AW;
    localparam int NCW = htbd_pkg::NODE_CW;
    localparam int SAW = htbd_pkg::STACK_AW;
    localparam int LW  = htbd_pkg::LEVEL_W;

    // Control state.
    logic [NCW-1:0] r_nodes,     n_nodes;
    logic [LW-1:0]  r_level,     n_level;
    logic           r_ready,     n_ready;
    logic           r_root_leaf, n_root_leaf;
    logic [NAW-1:0] r_walk,      n_walk;
    logic           r_s1_v,      n_s1_v;
    logic           r_below_byp, n_below_byp;

    // Payload state.
    htbd_pkg::t_pend r_top,        n_top;
    htbd_pkg::t_pend r_below_data, n_below_data;
    logic            r_s1_dec,     n_s1_dec;
    logic            r_s1_bit,     n_s1_bit;
    logic [1:0]      r_s1_kind,    n_s1_kind;

    // Memory ports.
    logic                 left_we, right_we, stack_we;
    htbd_pkg::t_child     child_wdata;
    logic [NAW-1:0]       node_raddr;
    logic [htbd_pkg::CHILD_W-1:0] left_rdata, right_rdata;
    logic [SAW-1:0]       stack_waddr, stack_raddr;
    htbd_pkg::t_pend      stack_wdata;
    logic [htbd_pkg::PEND_W-1:0] stack_rdata;

    // Stage-one and helper signals.
    logic             in_fire;
    htbd_pkg::t_child nxt;
    logic [NAW-1:0]   walk_res;
    logic             push;
    htbd_pkg::t_result push_data;
    htbd_pkg::t_pend  below;
    htbd_pkg::t_pend  top1;
    logic [LW-1:0]    lvl1;
    logic [LW-1:0]    rd_level;
    logic [LW-1:0]    wr_level;

    assign in_fire = i_in_valid && o_in_ready;

    // Resolve the decode bit whose child read has just returned.
    assign nxt      = r_s1_bit ? htbd_pkg::t_child'(right_rdata)
                               : htbd_pkg::t_child'(left_rdata);
    assign walk_res = (nxt.sym != 8'd0) ? '0 : nxt.idx;

    // The next bit reads from where this one lands.
    assign node_raddr = (r_s1_v && r_s1_dec) ? walk_res : r_walk;

    // Stage one hands a result on unless a decode bit stopped mid-code.
    assign push = r_s1_v && (!r_s1_dec || (nxt.sym != 8'd0));
    always_comb begin
        if (r_s1_dec) begin
            push_data.kind   = htbd_pkg::KIND_SYMBOL;
            push_data.symbol = nxt.sym;
        end else begin
            push_data.kind   = r_s1_kind;
            push_data.symbol = 8'd0;
        end
    end

    // Entry just below the top of the stack, forwarded after a push.
    assign below = r_below_byp ? r_below_data : htbd_pkg::t_pend'(stack_rdata);

    // Next-state logic for tree loading, decode issue and clear.
    always_comb begin
        n_nodes      = r_nodes;
        n_level      = r_level;
        n_ready      = r_ready;
        n_root_leaf  = r_root_leaf;
        n_walk       = r_walk;
        n_s1_v       = 1'b0;
        n_s1_dec     = 1'b0;
        n_s1_bit     = i_code_bit;
        n_s1_kind    = htbd_pkg::KIND_ERROR;
        n_below_byp  = 1'b0;
        n_below_data = r_below_data;
        n_top        = r_top;
        left_we      = 1'b0;
        right_we     = 1'b0;
        stack_we     = 1'b0;
        child_wdata.idx = r_nodes[NAW-1:0];
        child_wdata.sym = i_tree_byte;
        stack_wdata  = r_top;
        lvl1         = r_level;
        top1         = r_top;
        wr_level     = r_level - LW'(1);

        if (r_s1_v && r_s1_dec) begin
            n_walk = walk_res;
        end

        if (in_fire) begin
            case (i_op)
                htbd_pkg::OP_LOAD: begin
                    if (r_ready) begin
                        n_s1_v = 1'b1;
                    end else if (r_nodes >= NCW'(htbd_pkg::NODE_SLOTS)) begin
                        n_s1_v      = 1'b1;
                        n_nodes     = '0;
                        n_level     = '0;
                        n_ready     = 1'b0;
                        n_root_leaf = 1'b0;
                        n_walk      = '0;
                    end else begin
                        n_nodes = r_nodes + NCW'(1);
                        if (r_nodes == '0) begin
                            n_root_leaf = (i_tree_byte != 8'd0);
                        end
                        // Attach the new node to the waiting parent.
                        if (r_level != '0) begin
                            if (!r_top.left_done) begin
                                left_we        = 1'b1;
                                top1.left_done = 1'b1;
                            end else begin
                                right_we = 1'b1;
                                lvl1     = r_level - LW'(1);
                                top1     = below;
                            end
                        end
                        n_top   = top1;
                        n_level = lvl1;
                        // An internal node waits for its children.
                        if (i_tree_byte == 8'd0) begin
                            if (lvl1 >= LW'(htbd_pkg::STACK_SLOTS)) begin
                                n_s1_v      = 1'b1;
                                n_nodes     = '0;
                                n_level     = '0;
                                n_ready     = 1'b0;
                                n_root_leaf = 1'b0;
                                n_walk      = '0;
                            end else begin
                                if (lvl1 != '0) begin
                                    stack_we     = 1'b1;
                                    wr_level     = lvl1 - LW'(1);
                                    stack_wdata  = top1;
                                    n_below_byp  = 1'b1;
                                    n_below_data = top1;
                                end
                                n_top.node      = r_nodes[NAW-1:0];
                                n_top.left_done = 1'b0;
                                n_level         = lvl1 + LW'(1);
                            end
                        end else if (lvl1 == '0) begin
                            // Nothing is pending: the tree is complete.
                            n_ready   = 1'b1;
                            n_walk    = '0;
                            n_s1_v    = 1'b1;
                            n_s1_kind = htbd_pkg::KIND_COMPLETE;
                        end
                    end
                end
                htbd_pkg::OP_DECODE: begin
                    n_s1_v = 1'b1;
                    if (r_ready && !r_root_leaf) begin
                        n_s1_dec = 1'b1;
                    end
                end
                htbd_pkg::OP_CLEAR: begin
                    n_nodes     = '0;
                    n_level     = '0;
                    n_ready     = 1'b0;
                    n_root_leaf = 1'b0;
                    n_walk      = '0;
                end
                default: begin
                    n_s1_v = 1'b1;
                end
            endcase
        end
    end

    // The stack RAM always fetches the entry that will sit below the top.
    assign rd_level    = n_level - LW'(2);
    assign stack_raddr = rd_level[SAW-1:0];
    assign stack_waddr = wr_level[SAW-1:0];

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nodes     <= '0;
            r_level     <= '0;
            r_ready     <= 1'b0;
            r_root_leaf <= 1'b0;
            r_walk      <= '0;
            r_s1_v      <= 1'b0;
            r_below_byp <= 1'b0;
        end else begin
            r_nodes     <= n_nodes;
            r_level     <= n_level;
            r_ready     <= n_ready;
            r_root_leaf <= n_root_leaf;
            r_walk      <= n_walk;
            r_s1_v      <= n_s1_v;
            r_below_byp <= n_below_byp;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_top        <= n_top;
        r_below_data <= n_below_data;
        r_s1_dec     <= n_s1_dec;
        r_s1_bit     <= n_s1_bit;
        r_s1_kind    <= n_s1_kind;
    end

    // Left and right child links of every node.
    htbd_ram #(
        .WIDTH (htbd_pkg::CHILD_W),
        .DEPTH (htbd_pkg::NODE_SLOTS)
    ) u_left_ram (
        .i_clk   (i_clk),
        .i_we    (left_we),
        .i_waddr (r_top.node),
        .i_wdata (child_wdata),
        .i_raddr (node_raddr),
        .o_rdata (left_rdata)
    );

    htbd_ram #(
        .WIDTH (htbd_pkg::CHILD_W),
        .DEPTH (htbd_pkg::NODE_SLOTS)
    ) u_right_ram (
        .i_clk   (i_clk),
        .i_we    (right_we),
        .i_waddr (r_top.node),
        .i_wdata (child_wdata),
        .i_raddr (node_raddr),
        .o_rdata (right_rdata)
    );

    // Pending internal nodes below the top of the stack.
    htbd_ram #(
        .WIDTH (htbd_pkg::PEND_W),
        .DEPTH (htbd_pkg::STACK_SLOTS)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stack_we),
        .i_waddr (stack_waddr),
        .i_wdata (stack_wdata),
        .i_raddr (stack_raddr),
        .o_rdata (stack_rdata)
    );

    // Output register and skid stage.
    htbd_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pend      (r_s1_v),
        .o_room      (o_in_ready),
        .o_valid     (o_out_valid),
        .o_kind      (o_kind),
        .o_symbol    (o_symbol),
        .i_ready     (i_out_ready)
    );

endmodule

`default_nettype wire

// File: rtl/htbd_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
`default_nettype none

module htbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // A read of the address written in the same cycle returns the old data.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: rtl/htbd_out_buf.sv
// Result output register with a skid stage and the input credit check.
`default_nettype none

module htbd_out_buf (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire htbd_pkg::t_result i_push_data,
    input  wire logic              i_pend,
    output logic                   o_room,
    output logic                   o_valid,
    output logic [1:0]             o_kind,
    output logic [7:0]             o_symbol,
    input  wire logic              i_ready
);

    logic              r_out_v;
    logic              r_skid_v;
    htbd_pkg::t_result r_out;
    htbd_pkg::t_result r_skid;
    logic              taken;
    logic [1:0]        used;

    assign taken = r_out_v && i_ready;

    // Slots that will be claimed once the item in flight lands; a new item
    // is taken only if one slot stays free for it.
    assign used   = {1'b0, r_out_v} + {1'b0, r_skid_v} + {1'b0, i_pend} - {1'b0, taken};
    assign o_room = (used < 2'd2);

    // Control state of the two slots.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (taken || !r_out_v) begin
            r_out_v  <= r_skid_v || i_push;
            r_skid_v <= r_skid_v && i_push;
        end else if (i_push) begin
            r_skid_v <= 1'b1;
        end
    end

    // Result payload; the skid stage always drains first to keep order.
    always_ff @(posedge i_clk) begin
        if (taken || !r_out_v) begin
            r_out  <= r_skid_v ? r_skid : i_push_data;
            r_skid <= i_push_data;
        end else if (i_push) begin
            r_skid <= i_push_data;
        end
    end

    assign o_valid  = r_out_v;
    assign o_kind   = r_out.kind;
    assign o_symbol = r_out.symbol;

endmodule

`default_nettype wire

// File: rtl/htbd_checker.sv
// Port-level checks for the Huffman tree decoder, bound to its top level.
`default_nettype none

module htbd_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       o_in_ready,
    input wire logic [1:0] i_op,
    input wire logic       o_out_valid,
    input wire logic       i_out_ready,
    input wire logic [1:0] o_kind,
    input wire logic [7:0] o_symbol
);

    // A result waiting for transfer holds still.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_kind) && $stable(o_symbol))
        else $error("result changed while stalled");

    // Reset empties the output side.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result shown right after reset");

    // Only decoded symbols carry a symbol, and a leaf symbol is never zero.
    a_symbol_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind != htbd_pkg::KIND_SYMBOL) |-> o_symbol == 8'd0)
        else $error("non-symbol result carries a symbol");

    a_leaf_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == htbd_pkg::KIND_SYMBOL) |-> o_symbol != 8'd0)
        else $error("decoded symbol is zero");

    // A clear alone into an empty output side brings no result.
    a_clear_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid && !(i_in_valid && o_in_ready) ##1
        i_in_valid && o_in_ready && (i_op == htbd_pkg::OP_CLEAR) && !o_out_valid
        |=> !o_out_valid ##1 !o_out_valid)
        else $error("clear produced a result");

endmodule

bind huffman_tree_bit_decoder_unit htbd_checker u_htbd_checker (.*);

`default_nettype wire
